// ===== rtl/core/rational_arithmetic_unit_defines.svh =====
// Assertion helpers for the checker in rau_checker.sv.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// Consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int MAG_W         = 64;
    localparam int CNT_W         = $clog2(MAG_W);
    localparam int PC_W          = 5;
    localparam int REG_COUNT     = 8;
    localparam int IDX_W         = $clog2(REG_COUNT);

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [IDX_W-1:0] reg_idx_t;
    typedef logic [PC_W-1:0]  pc_t;

    // Commands
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_MUL   = 3'd2;
    localparam logic [2:0] CMD_DIV   = 3'd3;
    localparam logic [2:0] CMD_NEG   = 3'd4;
    localparam logic [2:0] CMD_RED   = 3'd5;
    localparam logic [2:0] CMD_TRUNC = 3'd6;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Working register slots
    localparam reg_idx_t R_AN = 3'd0;
    localparam reg_idx_t R_AD = 3'd1;
    localparam reg_idx_t R_BN = 3'd2;
    localparam reg_idx_t R_BD = 3'd3;
    localparam reg_idx_t R_M1 = 3'd4;
    localparam reg_idx_t R_M2 = 3'd5;
    localparam reg_idx_t R_RN = 3'd6;
    localparam reg_idx_t R_RD = 3'd7;

    localparam mag_t LIM_POS = {1'b0, {(MAG_W-1){1'b1}}};
    localparam mag_t LIM_NEG = {1'b1, {(MAG_W-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_GCD,   // g = gcd(a, b)
        OP_DIVG,  // d = a / g, g zero leaves a as it is
        OP_MUL,   // d = a * b
        OP_QUO,   // d = a / b
        OP_ADD,   // d = a + b, signed, with overflow check
        OP_SWAP,  // swap a and b, zero a is an error
        OP_MOVE,  // d = a
        OP_MOVN,  // d = -a
        OP_ONE,   // d = 1
        OP_END
    } uop_op_t;

    typedef struct packed {
        uop_op_t  op;
        reg_idx_t a;
        reg_idx_t b;
        reg_idx_t d;
    } uop_t;

    typedef struct packed {
        logic start;
        logic is_mul;
    } unit_req_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [FIELD_W-1:0] a_numerator;
        logic [FIELD_W-1:0] a_denominator;
        logic [FIELD_W-1:0] b_numerator;
        logic [FIELD_W-1:0] b_denominator;
    } item_t;

    typedef struct packed {
        mag_t       numerator;
        mag_t       denominator;
        logic [1:0] status;
    } result_t;

    function automatic uop_t mk_uop(uop_op_t op, reg_idx_t a, reg_idx_t b, reg_idx_t d);
        uop_t u;
        u.op = op;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // Microprogram: one step per program address.
    function automatic uop_t rau_uop(logic [2:0] cmd, pc_t pc);
        uop_t u;
        u = mk_uop(OP_END, R_AN, R_AN, R_AN);
        if (pc == 5'd0)
            u = mk_uop(OP_GCD, R_AN, R_AD, R_AN);
        else if (pc == 5'd1)
            u = mk_uop(OP_DIVG, R_AN, R_AN, R_AN);
        else if (pc == 5'd2)
            u = mk_uop(OP_DIVG, R_AD, R_AD, R_AD);
        else begin
            case (cmd) inside
                CMD_ADD, CMD_SUB:
                begin
                    case (pc)
                        5'd3:    u = mk_uop(OP_GCD, R_BN, R_BD, R_BN);
                        5'd4:    u = mk_uop(OP_DIVG, R_BN, R_BN, R_BN);
                        5'd5:    u = mk_uop(OP_DIVG, R_BD, R_BD, R_BD);
                        5'd6:    u = mk_uop(OP_GCD, R_AD, R_BD, R_AD);
                        5'd7:    u = mk_uop(OP_DIVG, R_BD, R_BD, R_M1);
                        5'd8:    u = mk_uop(OP_DIVG, R_AD, R_AD, R_M2);
                        5'd9:    u = mk_uop(OP_MUL, R_AN, R_M1, R_RN);
                        5'd10:   u = mk_uop(OP_MUL, R_BN, R_M2, R_M2);
                        5'd11:   u = mk_uop(OP_MUL, R_AD, R_M1, R_RD);
                        5'd12:   u = mk_uop(OP_ADD, R_RN, R_M2, R_RN);
                        5'd13:   u = mk_uop(OP_GCD, R_RN, R_RD, R_RN);
                        5'd14:   u = mk_uop(OP_DIVG, R_RN, R_RN, R_RN);
                        5'd15:   u = mk_uop(OP_DIVG, R_RD, R_RD, R_RD);
                        default: u = mk_uop(OP_END, R_AN, R_AN, R_AN);
                    endcase
                end
                CMD_MUL, CMD_DIV:
                begin
                    case (pc)
                        5'd3:    u = mk_uop(OP_GCD, R_BN, R_BD, R_BN);
                        5'd4:    u = mk_uop(OP_DIVG, R_BN, R_BN, R_BN);
                        5'd5:    u = mk_uop(OP_DIVG, R_BD, R_BD, R_BD);
                        5'd6:
                        begin
                            if (cmd == CMD_DIV)
                                u = mk_uop(OP_SWAP, R_BN, R_BD, R_BN);
                            else
                                u = mk_uop(OP_MOVE, R_AN, R_AN, R_AN);
                        end
                        5'd7:    u = mk_uop(OP_GCD, R_AN, R_BD, R_AN);
                        5'd8:    u = mk_uop(OP_DIVG, R_AN, R_AN, R_AN);
                        5'd9:    u = mk_uop(OP_DIVG, R_BD, R_BD, R_BD);
                        5'd10:   u = mk_uop(OP_GCD, R_AD, R_BN, R_AD);
                        5'd11:   u = mk_uop(OP_DIVG, R_AD, R_AD, R_AD);
                        5'd12:   u = mk_uop(OP_DIVG, R_BN, R_BN, R_BN);
                        5'd13:   u = mk_uop(OP_MUL, R_AN, R_BN, R_RN);
                        5'd14:   u = mk_uop(OP_MUL, R_AD, R_BD, R_RD);
                        5'd15:   u = mk_uop(OP_GCD, R_RN, R_RD, R_RN);
                        5'd16:   u = mk_uop(OP_DIVG, R_RN, R_RN, R_RN);
                        5'd17:   u = mk_uop(OP_DIVG, R_RD, R_RD, R_RD);
                        default: u = mk_uop(OP_END, R_AN, R_AN, R_AN);
                    endcase
                end
                CMD_NEG, CMD_RED:
                begin
                    case (pc)
                        5'd3:
                        begin
                            if (cmd == CMD_NEG)
                                u = mk_uop(OP_MOVN, R_AN, R_AN, R_RN);
                            else
                                u = mk_uop(OP_MOVE, R_AN, R_AN, R_RN);
                        end
                        5'd4:    u = mk_uop(OP_MOVE, R_AD, R_AD, R_RD);
                        5'd5:    u = mk_uop(OP_GCD, R_RN, R_RD, R_RN);
                        5'd6:    u = mk_uop(OP_DIVG, R_RN, R_RN, R_RN);
                        5'd7:    u = mk_uop(OP_DIVG, R_RD, R_RD, R_RD);
                        default: u = mk_uop(OP_END, R_AN, R_AN, R_AN);
                    endcase
                end
                default:
                begin
                    case (pc)
                        5'd3:    u = mk_uop(OP_QUO, R_AN, R_AD, R_RN);
                        5'd4:    u = mk_uop(OP_ONE, R_AN, R_AN, R_RD);
                        default: u = mk_uop(OP_END, R_AN, R_AN, R_AN);
                    endcase
                end
            endcase
        end
        return u;
    endfunction

    // Magnitude of the low OPERAND_WIDTH bits read as a signed value.
    function automatic mag_t field_mag(logic [FIELD_W-1:0] raw);
        logic [OPERAND_WIDTH-1:0] x;
        logic [OPERAND_WIDTH-1:0] xn;
        x  = raw[OPERAND_WIDTH-1:0];
        xn = ~x;
        if (x[OPERAND_WIDTH-1])
            return MAG_W'(xn) + MAG_W'(1);
        return MAG_W'(x);
    endfunction

    function automatic logic field_sign(logic [FIELD_W-1:0] raw);
        return raw[OPERAND_WIDTH-1];
    endfunction

    function automatic mag_t to_bits(logic neg, mag_t mag);
        if (neg && mag != '0)
            return '0 - mag;
        return mag;
    endfunction

endpackage

// ===== rtl/core/rau_if.sv =====
interface rau_in_if;
    import rau_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [FIELD_W-1:0] a_numerator;
    logic [FIELD_W-1:0] a_denominator;
    logic [FIELD_W-1:0] b_numerator;
    logic [FIELD_W-1:0] b_denominator;

    modport source (
        output valid, command, a_numerator, a_denominator, b_numerator, b_denominator,
        input  ready
    );
    modport sink (
        input  valid, command, a_numerator, a_denominator, b_numerator, b_denominator,
        output ready
    );
endinterface

interface rau_out_if;
    import rau_pkg::*;

    logic       valid;
    logic       ready;
    mag_t       result_numerator;
    mag_t       result_denominator;
    logic [1:0] status;

    modport source (
        output valid, result_numerator, result_denominator, status,
        input  ready
    );
    modport sink (
        input  valid, result_numerator, result_denominator, status,
        output ready
    );
endinterface

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Exact arithmetic on two signed fractions, result reduced by its gcd.
// in_ch carries a command (add, sub, mul, div, negate, reduce, truncate)
// and fractions a and b; out_ch returns numerator, denominator and status
// (ok, zero denominator, overflow). Both use valid/ready: an item moves at
// a rising edge with valid and ready high. Command 7 is dropped at once.
// One item at a time: in_ch.ready is high only while the sequencer idles.
// Multiply, divide and Euclid remainder steps run on one shared 64-bit
// shift/add unit; add, swap and move steps are done by the sequencer.
// Add or mul with long gcd chains need the most unit passes, since
// every Euclid step is one divide.
// A zero denominator skips the microprogram and goes straight to the
// result.
// The finished result is held in an output register; the sequencer may
// take a new item while it waits. If out_ch stalls, the next result waits
// in the sequencer and input is held off.
// Reset (rst_n, asynchronous, active low) empties the output register and
// returns the sequencer to idle; no clearing pass is needed.
module rational_arithmetic_unit (
    input logic      clk,
    input logic      rst_n,
    rau_in_if.sink   in_ch,
    rau_out_if.source out_ch
);
    import rau_pkg::*;

    item_t   item;
    result_t res;
    logic    res_valid;
    logic    res_ready;
    logic    out_valid_reg;
    result_t out_reg;

    assign item.command       = in_ch.command;
    assign item.a_numerator   = in_ch.a_numerator;
    assign item.a_denominator = in_ch.a_denominator;
    assign item.b_numerator   = in_ch.b_numerator;
    assign item.b_denominator = in_ch.b_denominator;

    rau_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result whenever the output slot is free or being emptied.
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Hold the payload until taken.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.result_numerator   = out_reg.numerator;
    assign out_ch.result_denominator = out_reg.denominator;
    assign out_ch.status             = out_reg.status;

endmodule

// ===== rtl/core/rau_serial.sv =====
module rau_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::unit_req_t req,
    input  rau_pkg::mag_t     op_a,
    input  rau_pkg::mag_t     op_b,
    output logic              done,
    output rau_pkg::mag_t     quo,
    output rau_pkg::mag_t     rem
);
    import rau_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             mul_reg;
    logic [CNT_W-1:0] cnt_reg;
    mag_t             p_reg;
    mag_t             q_reg;
    mag_t             acc_reg;

    logic [MAG_W:0]   shifted;
    logic [MAG_W+1:0] add_x;
    logic [MAG_W+1:0] add_y;
    logic [MAG_W+1:0] sum;
    logic             fits;

    // One shared adder: trial subtract for divide, accumulate for multiply.
    always_comb
    begin
        shifted = {acc_reg, q_reg[MAG_W-1]};
        if (mul_reg)
        begin
            add_x = {2'b00, acc_reg};
            add_y = q_reg[0] ? {2'b00, p_reg} : '0;
        end
        else
        begin
            add_x = {1'b0, shifted};
            add_y = {2'b11, ~p_reg};
        end
        sum  = add_x + add_y + (MAG_W+2)'(!mul_reg);
        fits = !sum[MAG_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == {CNT_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mul_reg <= req.is_mul;
            acc_reg <= '0;
            p_reg   <= op_b;
            q_reg   <= op_a;
        end
        else if (busy_reg)
        begin
            if (mul_reg)
            begin
                acc_reg <= sum[MAG_W-1:0];
                p_reg   <= {p_reg[MAG_W-2:0], 1'b0};
                q_reg   <= {1'b0, q_reg[MAG_W-1:1]};
            end
            else
            begin
                acc_reg <= fits ? sum[MAG_W-1:0] : shifted[MAG_W-1:0];
                q_reg   <= {q_reg[MAG_W-2:0], fits};
            end
        end
    end

    assign done = done_reg;
    assign quo  = mul_reg ? acc_reg : q_reg;
    assign rem  = acc_reg;

endmodule

// ===== rtl/core/rau_core.sv =====
module rau_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rau_pkg::item_t   item,
    output logic             res_valid,
    input  logic             res_ready,
    output rau_pkg::result_t res
);
    import rau_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_GCD  = 6'b000100,
        S_GMOD = 6'b001000,
        S_WAIT = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t         state_reg;
    logic [2:0]     cmd_reg;
    pc_t            pc_reg;
    logic [1:0]     status_reg;
    mag_t           mag_reg [REG_COUNT];
    logic [REG_COUNT-1:0] sgn_reg;
    mag_t           ga_reg;
    mag_t           gb_reg;
    mag_t           g_reg;
    reg_idx_t       wdst_reg;
    logic           wsgn_reg;

    uop_t           uop;
    mag_t           ra;
    mag_t           rb;
    logic           sa;
    logic           sb;
    logic           accept;
    logic           zero_den;
    mag_t           in_ad_mag;
    mag_t           in_bd_mag;

    logic           same_sign;
    logic [MAG_W:0] add_sum;
    mag_t           add_lim;
    logic           add_ovf;
    logic           a_ge;
    mag_t           add_mag;
    logic           add_sgn;

    unit_req_t      req;
    mag_t           unit_a;
    mag_t           unit_b;
    logic           unit_done;
    mag_t           unit_quo;
    mag_t           unit_rem;

    assign uop = rau_uop(cmd_reg, pc_reg);
    assign ra  = mag_reg[uop.a];
    assign rb  = mag_reg[uop.b];
    assign sa  = sgn_reg[uop.a];
    assign sb  = sgn_reg[uop.b];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_ad_mag = field_mag(item.a_denominator);
    assign in_bd_mag = field_mag(item.b_denominator);
    assign zero_den  = (in_ad_mag == '0) || (item.command <= CMD_DIV && in_bd_mag == '0);

    // Signed add on sign and magnitude
    always_comb
    begin
        same_sign = (sa == sb);
        add_sum   = {1'b0, ra} + {1'b0, rb};
        add_lim   = sa ? LIM_NEG : LIM_POS;
        add_ovf   = same_sign && (ra > add_lim || add_sum > {1'b0, add_lim});
        a_ge      = (ra >= rb);
        if (same_sign)
        begin
            add_mag = add_sum[MAG_W-1:0];
            add_sgn = sa;
        end
        else
        begin
            add_mag = a_ge ? (ra - rb) : (rb - ra);
            add_sgn = a_ge ? sa : sb;
        end
    end

    always_comb
    begin
        req.start  = 1'b0;
        req.is_mul = (uop.op == OP_MUL);
        unit_a     = ra;
        unit_b     = rb;
        if (state_reg == S_GCD)
        begin
            req.start  = (gb_reg != '0);
            req.is_mul = 1'b0;
            unit_a     = ga_reg;
            unit_b     = gb_reg;
        end
        else if (state_reg == S_EXEC)
        begin
            case (uop.op) inside
                OP_DIVG:
                begin
                    req.start = (g_reg != '0);
                    unit_b    = g_reg;
                end
                OP_MUL, OP_QUO: req.start = 1'b1;
                default:        req.start = 1'b0;
            endcase
        end
    end

    rau_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .op_a  (unit_a),
        .op_b  (unit_b),
        .done  (unit_done),
        .quo   (unit_quo),
        .rem   (unit_rem)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_ADD;
            pc_reg     <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && item.command <= CMD_TRUNC)
                    begin
                        cmd_reg <= item.command;
                        pc_reg  <= '0;
                        if (zero_den)
                        begin
                            status_reg <= STATUS_ZERO_DEN;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    case (uop.op) inside
                        OP_GCD: state_reg <= S_GCD;
                        OP_DIVG:
                        begin
                            if (g_reg == '0)
                                pc_reg <= pc_reg + PC_W'(1);
                            else
                                state_reg <= S_WAIT;
                        end
                        OP_MUL, OP_QUO: state_reg <= S_WAIT;
                        OP_ADD:
                        begin
                            if (add_ovf)
                            begin
                                status_reg <= STATUS_OVERFLOW;
                                state_reg  <= S_DONE;
                            end
                            else
                                pc_reg <= pc_reg + PC_W'(1);
                        end
                        OP_SWAP:
                        begin
                            if (ra == '0)
                            begin
                                status_reg <= STATUS_ZERO_DEN;
                                state_reg  <= S_DONE;
                            end
                            else
                                pc_reg <= pc_reg + PC_W'(1);
                        end
                        OP_END: state_reg <= S_DONE;
                        default: pc_reg <= pc_reg + PC_W'(1);
                    endcase
                end
                S_GCD:
                begin
                    if (gb_reg == '0)
                    begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_EXEC;
                    end
                    else
                        state_reg <= S_GMOD;
                end
                S_GMOD:
                begin
                    if (unit_done)
                        state_reg <= S_GCD;
                end
                S_WAIT:
                begin
                    if (unit_done)
                    begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_EXEC;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mag_reg[R_AN] <= field_mag(item.a_numerator);
                    mag_reg[R_AD] <= in_ad_mag;
                    mag_reg[R_BN] <= field_mag(item.b_numerator);
                    mag_reg[R_BD] <= in_bd_mag;
                    sgn_reg[R_AN] <= field_sign(item.a_numerator);
                    sgn_reg[R_AD] <= field_sign(item.a_denominator);
                    sgn_reg[R_BN] <= field_sign(item.b_numerator) ^ (item.command == CMD_SUB);
                    sgn_reg[R_BD] <= field_sign(item.b_denominator);
                end
            end
            S_EXEC:
            begin
                case (uop.op) inside
                    OP_GCD:
                    begin
                        ga_reg <= ra;
                        gb_reg <= rb;
                    end
                    OP_DIVG:
                    begin
                        if (g_reg == '0)
                        begin
                            mag_reg[uop.d] <= ra;
                            sgn_reg[uop.d] <= sa;
                        end
                        wdst_reg <= uop.d;
                        wsgn_reg <= sa;
                    end
                    OP_MUL, OP_QUO:
                    begin
                        wdst_reg <= uop.d;
                        wsgn_reg <= sa ^ sb;
                    end
                    OP_ADD:
                    begin
                        mag_reg[uop.d] <= add_mag;
                        sgn_reg[uop.d] <= add_sgn;
                    end
                    OP_SWAP:
                    begin
                        mag_reg[uop.a] <= rb;
                        mag_reg[uop.b] <= ra;
                        sgn_reg[uop.a] <= sb;
                        sgn_reg[uop.b] <= sa;
                    end
                    OP_MOVE:
                    begin
                        mag_reg[uop.d] <= ra;
                        sgn_reg[uop.d] <= sa;
                    end
                    OP_MOVN:
                    begin
                        mag_reg[uop.d] <= ra;
                        sgn_reg[uop.d] <= !sa;
                    end
                    OP_ONE:
                    begin
                        mag_reg[uop.d] <= MAG_W'(1);
                        sgn_reg[uop.d] <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_GCD:
            begin
                if (gb_reg == '0)
                    g_reg <= ga_reg;
            end
            S_GMOD:
            begin
                if (unit_done)
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= unit_rem;
                end
            end
            S_WAIT:
            begin
                if (unit_done)
                begin
                    mag_reg[wdst_reg] <= unit_quo;
                    sgn_reg[wdst_reg] <= wsgn_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status = status_reg;
        if (status_reg == STATUS_OK)
        begin
            res.numerator   = to_bits(sgn_reg[R_RN], mag_reg[R_RN]);
            res.denominator = to_bits(sgn_reg[R_RD], mag_reg[R_RD]);
        end
        else
        begin
            res.numerator   = '0;
            res.denominator = '0;
        end
    end

endmodule

// ===== rtl/core/rau_checker.sv =====
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [2:0]          command,
    input logic                out_valid,
    input logic                out_ready,
    input rau_pkg::mag_t       res_num,
    input rau_pkg::mag_t       res_den,
    input logic [1:0]          status
);
    import rau_pkg::*;

    // An error result carries no fraction.
    `RAU_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && status != STATUS_OK, res_num == '0 && res_den == '0)
    // A good result never has a zero denominator.
    `RAU_ASSERT_SAME(a_ok_den, clk, rst_n, out_valid && status == STATUS_OK, res_den != '0)
    // A real command holds off input while it is worked on.
    `RAU_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready && command <= CMD_TRUNC, !in_ready)
    // A stalled result holds.
    `RAU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_num) && $stable(res_den) && $stable(status))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .command   (in_ch.command),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_num   (out_ch.result_numerator),
    .res_den   (out_ch.result_denominator),
    .status    (out_ch.status)
);
